FILE: rtl/sfc_pkg.sv
// Package for the sensor frame checker: frame layout, CRC constants,
// status and register codes, and the byte-wide CRC-16 update. No dependencies.
`default_nettype none

package sfc_pkg;

  localparam int unsigned FRAME_BYTES = 23;
  localparam int unsigned CRC_BYTES   = 21;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  // Byte offsets inside the frame
  localparam logic [COUNT_W-1:0] POS_VERSION  = COUNT_W'(0);
  localparam logic [COUNT_W-1:0] POS_ID_LAST  = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] POS_DIST_END = COUNT_W'(6);
  localparam logic [COUNT_W-1:0] POS_QUALITY  = COUNT_W'(7);
  localparam logic [COUNT_W-1:0] POS_TIME_END = COUNT_W'(15);
  localparam logic [COUNT_W-1:0] POS_ALIVE    = COUNT_W'(16);
  localparam logic [COUNT_W-1:0] POS_DIAG_END = COUNT_W'(20);
  localparam logic [COUNT_W-1:0] POS_CRC_END  = COUNT_W'(FRAME_BYTES - 1);
  localparam logic [COUNT_W-1:0] POS_CRC_LIM  = COUNT_W'(CRC_BYTES);
  localparam logic [COUNT_W-1:0] POS_LAST     = COUNT_W'(FRAME_BYTES - 1);

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_BAD_LENGTH  = 3'd1,
    STATUS_BAD_VERSION = 3'd2,
    STATUS_BAD_QUALITY = 3'd3,
    STATUS_BAD_CRC     = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPECTED_VERSION = 2'd0,
    REG_QUALITY_VALID    = 2'd1,
    REG_QUALITY_DEGRADED = 2'd2,
    REG_QUALITY_INVALID  = 2'd3
  } reg_idx_e;

  // CRC-16, MSB first, one byte: eight shift and conditional XOR steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sensor_frame_checker_unpacker.sv
// Sensor frame checker and unpacker: byte-serial CRC-16 check and field capture.
// Depends on sfc_pkg for layout, CRC update and status codes.
// The result is registered and valid in the cycle after the final byte's transaction.
// Throughput: one byte per cycle while no result is stalled, set by the byte-wide
// CRC update feeding its own register; a new frame may start right after a final byte if the result is taken.
// Reset clears frame state and the result valid flag and loads register defaults.
`default_nettype none

module sensor_frame_checker_unpacker (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration write port
  input  wire                          cfg_we_i,
  input  wire [sfc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [sfc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // byte input channel
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire [7:0]                    frame_byte_i,
  input  wire                          frame_end_i,
  // result channel
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [2:0]                   status_o,
  output logic [15:0]                  node_id_o,
  output logic [31:0]                  range_mm_o,
  output logic [7:0]                   quality_o,
  output logic [63:0]                  stamp_ns_o,
  output logic [7:0]                   live_count_o,
  output logic [31:0]                  diagnostic_word_o
);
  import sfc_pkg::*;

  // configuration registers
  logic [7:0] exp_version_q, q_valid_q, q_degraded_q, q_invalid_q;

  // frame state
  logic [COUNT_W-1:0] byte_count_q, byte_count_d;
  logic [15:0] running_crc_q, running_crc_d;
  logic [15:0] received_crc_q, received_crc_d;
  logic [7:0]  version_q, version_d;
  logic [15:0] id_q, id_d;
  logic [31:0] dist_q, dist_d;
  logic [7:0]  quality_q, quality_d;
  logic [63:0] time_q, time_d;
  logic [7:0]  alive_q, alive_d;
  logic [31:0] diag_q, diag_d;

  // result register
  logic        out_valid_q;
  status_e     status_q, status_d;
  logic [15:0] res_id_q;
  logic [31:0] res_dist_q;
  logic [7:0]  res_quality_q;
  logic [63:0] res_time_q;
  logic [7:0]  res_alive_q;
  logic [31:0] res_diag_q;

  logic in_fire, out_fire;
  logic [COUNT_W-1:0] pos;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;
  assign pos        = byte_count_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_version_q <= 8'd1;
      q_valid_q     <= 8'd0;
      q_degraded_q  <= 8'd1;
      q_invalid_q   <= 8'd2;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_EXPECTED_VERSION: exp_version_q <= cfg_data_i;
        REG_QUALITY_VALID:    q_valid_q     <= cfg_data_i;
        REG_QUALITY_DEGRADED: q_degraded_q  <= cfg_data_i;
        REG_QUALITY_INVALID:  q_invalid_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the current byte into its field and advance the CRC over bytes before the CRC field
  always_comb begin
    running_crc_d  = running_crc_q;
    received_crc_d = received_crc_q;
    version_d      = version_q;
    id_d           = id_q;
    dist_d         = dist_q;
    quality_d      = quality_q;
    time_d         = time_q;
    alive_d        = alive_q;
    diag_d         = diag_q;
    if (pos < POS_CRC_LIM) begin
      running_crc_d = crc16_byte(running_crc_q, frame_byte_i);
    end
    if (pos == POS_VERSION) begin
      version_d = frame_byte_i;
    end else if (pos <= POS_ID_LAST) begin
      id_d = {id_q[7:0], frame_byte_i};
    end else if (pos <= POS_DIST_END) begin
      dist_d = {dist_q[23:0], frame_byte_i};
    end else if (pos == POS_QUALITY) begin
      quality_d = frame_byte_i;
    end else if (pos <= POS_TIME_END) begin
      time_d = {time_q[55:0], frame_byte_i};
    end else if (pos == POS_ALIVE) begin
      alive_d = frame_byte_i;
    end else if (pos <= POS_DIAG_END) begin
      diag_d = {diag_q[23:0], frame_byte_i};
    end else if (pos <= POS_CRC_END) begin
      received_crc_d = {received_crc_q[7:0], frame_byte_i};
    end
    byte_count_d = (byte_count_q == COUNT_MAX) ? byte_count_q : byte_count_q + 1'b1;
  end

  // Run the status checks in priority order on the updated frame state
  always_comb begin
    if (pos != POS_LAST) begin
      status_d = STATUS_BAD_LENGTH;
    end else if (version_d != exp_version_q) begin
      status_d = STATUS_BAD_VERSION;
    end else if (quality_d != q_valid_q && quality_d != q_degraded_q &&
                 quality_d != q_invalid_q) begin
      status_d = STATUS_BAD_QUALITY;
    end else if (running_crc_d != received_crc_d) begin
      status_d = STATUS_BAD_CRC;
    end else begin
      status_d = STATUS_OK;
    end
  end

  // Hold frame state; clear it after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q   <= '0;
      running_crc_q  <= CRC_INIT;
      received_crc_q <= '0;
      version_q      <= '0;
      id_q           <= '0;
      dist_q         <= '0;
      quality_q      <= '0;
      time_q         <= '0;
      alive_q        <= '0;
      diag_q         <= '0;
    end else if (in_fire) begin
      if (frame_end_i) begin
        byte_count_q   <= '0;
        running_crc_q  <= CRC_INIT;
        received_crc_q <= '0;
        version_q      <= '0;
        id_q           <= '0;
        dist_q         <= '0;
        quality_q      <= '0;
        time_q         <= '0;
        alive_q        <= '0;
        diag_q         <= '0;
      end else begin
        byte_count_q   <= byte_count_d;
        running_crc_q  <= running_crc_d;
        received_crc_q <= received_crc_d;
        version_q      <= version_d;
        id_q           <= id_d;
        dist_q         <= dist_d;
        quality_q      <= quality_d;
        time_q         <= time_d;
        alive_q        <= alive_d;
        diag_q         <= diag_d;
      end
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && frame_end_i) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result payload; zero the fields on any failed check
  always_ff @(posedge clk_i) begin
    if (in_fire && frame_end_i) begin
      status_q <= status_d;
      if (status_d == STATUS_OK) begin
        res_id_q      <= id_d;
        res_dist_q    <= dist_d;
        res_quality_q <= quality_d;
        res_time_q    <= time_d;
        res_alive_q   <= alive_d;
        res_diag_q    <= diag_d;
      end else begin
        res_id_q      <= '0;
        res_dist_q    <= '0;
        res_quality_q <= '0;
        res_time_q    <= '0;
        res_alive_q   <= '0;
        res_diag_q    <= '0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign node_id_o         = res_id_q;
  assign range_mm_o        = res_dist_q;
  assign quality_o         = res_quality_q;
  assign stamp_ns_o        = res_time_q;
  assign live_count_o      = res_alive_q;
  assign diagnostic_word_o = res_diag_q;

  // A stalled result blocks new bytes
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while result stalled");

  // Frame state restarts after a final byte
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && frame_end_i) |=> (byte_count_q == '0 && running_crc_q == CRC_INIT))
    else $error("frame state not cleared after final byte");

  // Failed frames carry zeroed fields
  a_error_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != STATUS_OK) |->
      (res_id_q == '0 && res_dist_q == '0 && res_time_q == '0 && res_diag_q == '0))
    else $error("error result with nonzero fields");

  // A non-final byte never produces a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !(in_fire && frame_end_i)) |=> !out_valid_q)
    else $error("result without final byte");

endmodule

`default_nettype wire
